FILE: rtl/core/lrt_pkg.sv
// Shared types and constants for the LRU replacement tracker.
// No dependencies; used by lrt_cell and lru_replacement_tracker.
package lrt_pkg;

   // Default configuration
   localparam int CAPACITY_DEFAULT = 16;
   localparam int KEY_BITS_DEFAULT = 31;

   // Fixed port widths
   localparam int PORT_KEY_W   = 31;
   localparam int PORT_COUNT_W = 5;

   // Request type codes
   localparam logic REQ_ACCESS = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Per-item command broadcast to every cell
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TOUCH,
      CMD_INSERT,
      CMD_REMOVE
   } cmd_type;

   // Top-level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   // Broadcast control into the cell row
   typedef struct packed {
      cmd_type cmd;
      logic    capture;
   } cell_ctl_type;

   // Flags handed from one cell to the next
   typedef struct packed {
      logic free_seen;
      logic vic_found;
   } chain_type;

endpackage

FILE: rtl/core/lrt_cell.sv
// One slot of the LRU tracker: key, valid bit and recency rank.
// Depends on lrt_pkg; instantiated in a row by lru_replacement_tracker.
module lrt_cell #(
   parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEFAULT,
   parameter int RANK_W   = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrt_pkg::cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [RANK_W-1:0]     ref_rank,
   input  logic [RANK_W-1:0]     vic_rank,
   input  lrt_pkg::chain_type    chain_in,
   input  logic [KEY_BITS-1:0]   vic_key_in,
   output lrt_pkg::chain_type    chain_out,
   output logic [KEY_BITS-1:0]   vic_key_out,
   output logic                  match,
   output logic [RANK_W-1:0]     rank
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic                match_ff, match_in;
   logic                first_free_ff, first_free_in;
   logic                first_free;
   logic                is_vic;

   assign match      = valid_ff && (key_ff == req_key);
   assign rank       = rank_ff;
   assign first_free = !valid_ff && !chain_in.free_seen;
   assign is_vic     = valid_ff && (rank_ff == vic_rank) && !chain_in.vic_found;

   assign chain_out.free_seen = chain_in.free_seen | ~valid_ff;
   assign chain_out.vic_found = chain_in.vic_found | is_vic;
   assign vic_key_out         = is_vic ? key_ff : vic_key_in;

   always_comb begin
      key_in        = key_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      match_in      = match_ff;
      first_free_in = first_free_ff;
      if (ctl.capture) begin
         match_in      = match;
         first_free_in = first_free;
      end
      case (ctl.cmd)
         lrt_pkg::CMD_TOUCH: begin
            if (match_ff) begin
               rank_in = '0;
            end else if (valid_ff && (rank_ff < ref_rank)) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         lrt_pkg::CMD_INSERT: begin
            if (first_free_ff) begin
               key_in   = req_key;
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         lrt_pkg::CMD_REMOVE: begin
            if (match_ff) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff > ref_rank)) begin
               rank_in = rank_ff - RANK_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff      <= 1'b0;
         rank_ff       <= '0;
         match_ff      <= 1'b0;
         first_free_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         rank_ff       <= rank_in;
         match_ff      <= match_in;
         first_free_ff <= first_free_in;
      end
   end

endmodule

FILE: rtl/core/lru_replacement_tracker.sv
// LRU replacement tracker: a row of CAPACITY cells plus a small sequencer.
// A request beat passes through lookup, update and victim report into the output
// register; a new beat is taken only once the response is loaded, which waits
// while a response is held off. The sequencer owns the cell row for the whole item.
// Reset (synchronous, active high) empties all slots and clears the count.
// Depends on lrt_pkg and lrt_cell.
module lru_replacement_tracker #(
   parameter int CAPACITY = lrt_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [lrt_pkg::PORT_KEY_W-1:0]    req_page_key,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic                              rsp_rejected,
   output logic                              rsp_victim_valid,
   output logic [lrt_pkg::PORT_KEY_W-1:0]    rsp_victim_key,
   output logic [lrt_pkg::PORT_COUNT_W-1:0]  rsp_entry_count
);

   localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // wide enough for both the count and the response field
   localparam int CNT_WIDE_W = (CNT_W > lrt_pkg::PORT_COUNT_W) ? CNT_W
                                                               : lrt_pkg::PORT_COUNT_W;

   // sequencer state and captured request
   lrt_pkg::state_type  state_ff, state_in;
   logic                req_type_ff, req_type_in;
   logic [KEY_BITS-1:0] req_key_ff, req_key_in;
   logic                hit_ff, hit_in;
   logic                rejected_ff, rejected_in;
   logic [RANK_W-1:0]   hit_rank_ff, hit_rank_in;
   lrt_pkg::cmd_type    cmd_ff, cmd_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic                           rsp_rejected_ff, rsp_rejected_in;
   logic                           rsp_vvalid_ff, rsp_vvalid_in;
   logic [lrt_pkg::PORT_KEY_W-1:0] rsp_vkey_ff, rsp_vkey_in;
   logic [lrt_pkg::PORT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // cell row wiring
   lrt_pkg::cell_ctl_type ctl;
   lrt_pkg::chain_type    chain [CAPACITY+1];
   logic [KEY_BITS-1:0]   vic_key [CAPACITY+1];
   logic [CAPACITY-1:0]   match_vec;
   logic [RANK_W-1:0]     rank_vec [CAPACITY];
   logic                  any_match;
   logic [RANK_W-1:0]     match_rank;
   logic [RANK_W-1:0]     vic_rank;
   logic [CNT_WIDE_W-1:0] count_wide;

   assign chain[0]   = '{free_seen: 1'b0, vic_found: 1'b0};
   assign vic_key[0] = '0;

   // the oldest slot carries rank count-1
   assign vic_rank = RANK_W'(count_ff - CNT_W'(1));

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         lrt_cell #(
            .KEY_BITS (KEY_BITS),
            .RANK_W   (RANK_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .req_key     (req_key_ff),
            .ref_rank    (hit_rank_ff),
            .vic_rank    (vic_rank),
            .chain_in    (chain[gi]),
            .vic_key_in  (vic_key[gi]),
            .chain_out   (chain[gi+1]),
            .vic_key_out (vic_key[gi+1]),
            .match       (match_vec[gi]),
            .rank        (rank_vec[gi])
         );
      end
   endgenerate

   // at most one slot matches, so OR-ing the masked ranks gives its rank
   always_comb begin
      match_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_rank = match_rank | (rank_vec[i] & {RANK_W{match_vec[i]}});
      end
   end
   assign any_match = |match_vec;

   assign count_wide = CNT_WIDE_W'(count_ff);

   // sequencer: next state, cell control, response load
   always_comb begin
      state_in        = state_ff;
      req_type_in     = req_type_ff;
      req_key_in      = req_key_ff;
      hit_in          = hit_ff;
      rejected_in     = rejected_ff;
      hit_rank_in     = hit_rank_ff;
      cmd_in          = cmd_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_vvalid_in   = rsp_vvalid_ff;
      rsp_vkey_in     = rsp_vkey_ff;
      rsp_count_in    = rsp_count_ff;
      req_ready       = 1'b0;
      ctl.cmd         = lrt_pkg::CMD_NONE;
      ctl.capture     = 1'b0;

      case (state_ff)
         lrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_type_in = req_type;
               req_key_in  = req_page_key[KEY_BITS-1:0];
               state_in    = lrt_pkg::ST_LOOKUP;
            end
         end
         lrt_pkg::ST_LOOKUP: begin
            // cells latch their match and first-free flags this cycle
            ctl.capture = 1'b1;
            hit_in      = any_match;
            hit_rank_in = match_rank;
            rejected_in = 1'b0;
            if (req_type_ff == lrt_pkg::REQ_REMOVE) begin
               cmd_in = any_match ? lrt_pkg::CMD_REMOVE : lrt_pkg::CMD_NONE;
            end else if (any_match) begin
               cmd_in = lrt_pkg::CMD_TOUCH;
            end else if (chain[CAPACITY].free_seen) begin
               cmd_in = lrt_pkg::CMD_INSERT;
            end else begin
               cmd_in      = lrt_pkg::CMD_NONE;
               rejected_in = 1'b1;
            end
            state_in = lrt_pkg::ST_UPDATE;
         end
         lrt_pkg::ST_UPDATE: begin
            ctl.cmd = cmd_ff;
            case (cmd_ff)
               lrt_pkg::CMD_INSERT: count_in = count_ff + CNT_W'(1);
               lrt_pkg::CMD_REMOVE: count_in = count_ff - CNT_W'(1);
               default:             count_in = count_ff;
            endcase
            state_in = lrt_pkg::ST_REPORT;
         end
         lrt_pkg::ST_REPORT: begin
            // victim chain settles on the updated row; load when the slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_rejected_in = rejected_ff;
               rsp_vvalid_in   = chain[CAPACITY].vic_found;
               rsp_vkey_in     = chain[CAPACITY].vic_found ?
                                 lrt_pkg::PORT_KEY_W'(vic_key[CAPACITY]) : '0;
               rsp_count_in    = count_wide[lrt_pkg::PORT_COUNT_W-1:0];
               state_in        = lrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_type_ff     <= req_type_in;
      req_key_ff      <= req_key_in;
      hit_rank_ff     <= hit_rank_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_rejected_ff <= rsp_rejected_in;
      rsp_vvalid_ff   <= rsp_vvalid_in;
      rsp_vkey_ff     <= rsp_vkey_in;
      rsp_count_ff    <= rsp_count_in;
      if (reset) begin
         state_ff     <= lrt_pkg::ST_IDLE;
         hit_ff       <= 1'b0;
         rejected_ff  <= 1'b0;
         cmd_ff       <= lrt_pkg::CMD_NONE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         rejected_ff  <= rejected_in;
         cmd_ff       <= cmd_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_rejected     = rsp_rejected_ff;
   assign rsp_victim_valid = rsp_vvalid_ff;
   assign rsp_victim_key   = rsp_vkey_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule
